[rtl/core/lns_pkg.sv]
// ----------------------------------------------------------------------------
// lns_pkg - shared types and constants for the natural log series block
// Sequencer states, shared arithmetic unit request/response and fixed-point
// constants.
// ----------------------------------------------------------------------------
package lns_pkg;

    localparam int          Q_FRAC    = 30;     // fraction bits of z and terms
    localparam int          SUM_W     = 34;     // sum of term magnitudes, Q4.30
    localparam int          DIV_STEPS = 30;     // quotient bits per division
    localparam int          DV_W      = 33;     // divisor width
    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [23:0] EPS_RESET = 24'd168;
    localparam logic [32:0] LOG_MAX_NEG_MAG = 33'h0_8000_0000;
    localparam logic [32:0] LOG_MAX_POS     = 33'h0_7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_Z_GO,
        ST_Z_WAIT,
        ST_ZZ_GO,
        ST_ZZ_WAIT,
        ST_TM_GO,
        ST_TM_WAIT,
        ST_TS_GO,
        ST_TS_WAIT,
        ST_TD_GO,
        ST_TD_WAIT,
        ST_ACC,
        ST_OUT
    } t_state;

    typedef enum logic {
        UOP_MUL,
        UOP_DIV
    } t_unit_op;

    typedef struct packed {
        logic        start;
        t_unit_op    op;
        logic [31:0] mul_a;
        logic [31:0] mul_b;
        logic [63:0] dividend;  // quotient must fit in DIV_STEPS bits
        logic [32:0] divisor;
    } t_unit_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_unit_rsp;

endpackage

[rtl/core/natural_log_series.sv]
// A zero argument goes straight to output; otherwise the bit-serial divider on
// the shared unit runs once for z and once per term added after the first. A
// new beat is taken once the sequencer is idle; the last result may still wait.
// Reset (synchronous, active low) returns to idle and sets epsilon to 168.
// ----------------------------------------------------------------------------
// natural_log_series - ln(x) by the atanh series
// Sequencer driving one shared multiply/divide unit; Q16.16 in, Q8.24 out.
// ----------------------------------------------------------------------------
module natural_log_series
    import lns_pkg::*;
#(
    parameter int MAX_TERMS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,    // epsilon, Q0.24
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] x_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] log_value, [44:32] terms_used
    output logic [1:0]  m_axis_tuser    // [0] valid_res, [1] hit_limit
);

    localparam int NW = $clog2(MAX_TERMS + 1);
    localparam logic [NW-1:0] N_CAP = NW'(MAX_TERMS);

    t_state          r_state, n_state;
    logic [23:0]     r_eps;
    logic            r_zero;
    logic            r_neg;
    logic [31:0]     r_num;
    logic [32:0]     r_den;
    logic [29:0]     r_zmag;
    logic [29:0]     r_zz;
    logic [29:0]     r_term;
    logic [SUM_W-1:0] r_sum;
    logic [NW-1:0]   r_n;
    logic            r_m_valid;
    logic [47:0]     r_m_data;
    logic [1:0]      r_m_user;

    t_unit_req       w_req;
    t_unit_rsp       w_rsp;
    logic [NW:0]     w_odd;
    logic [29:0]     w_thr;
    logic            w_above;
    logic            w_accept;
    logic            w_out_free;
    logic [32:0]     w_mag;
    logic [32:0]     w_mag_sat;
    logic [31:0]     w_log;
    logic [31:0]     w_n32;

    lns_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_odd      = {r_n, 1'b0} - 1'b1;
    assign w_thr      = {r_eps, 6'b0};
    assign w_above    = r_term >= w_thr;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_n32      = 32'(r_n);

    // 2*sum in Q8.24, sign applied, saturated
    always_comb begin
        w_mag = 33'(r_sum >> 5);
        if (r_neg) begin
            w_mag_sat = (w_mag > LOG_MAX_NEG_MAG) ? LOG_MAX_NEG_MAG : w_mag;
            w_log     = 32'(33'd0 - w_mag_sat);
        end else begin
            w_mag_sat = (w_mag > LOG_MAX_POS) ? LOG_MAX_POS : w_mag;
            w_log     = w_mag_sat[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (s_axis_tvalid) begin
                n_state = (s_axis_tdata == 32'd0) ? ST_OUT : ST_Z_GO;
            end
            ST_Z_GO:    n_state = ST_Z_WAIT;
            ST_Z_WAIT:  if (w_rsp.done) n_state = ST_ZZ_GO;
            ST_ZZ_GO:   n_state = ST_ZZ_WAIT;
            ST_ZZ_WAIT: if (w_rsp.done) n_state = ST_TM_GO;
            ST_TM_GO:   n_state = ST_TM_WAIT;
            ST_TM_WAIT: if (w_rsp.done) n_state = ST_TS_GO;
            ST_TS_GO:   n_state = ST_TS_WAIT;
            ST_TS_WAIT: if (w_rsp.done) n_state = ST_TD_GO;
            ST_TD_GO:   n_state = ST_TD_WAIT;
            ST_TD_WAIT: if (w_rsp.done) n_state = ST_ACC;
            ST_ACC:     n_state = (w_above && r_n < N_CAP) ? ST_TM_GO : ST_OUT;
            ST_OUT:     if (w_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready  = 1'b0;
        w_req.start    = 1'b0;
        w_req.op       = UOP_MUL;
        w_req.mul_a    = '0;
        w_req.mul_b    = '0;
        w_req.dividend = '0;
        w_req.divisor  = '0;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_Z_GO: begin
                w_req.start    = 1'b1;
                w_req.op       = UOP_DIV;
                w_req.dividend = {2'b0, r_num, 30'b0};
                w_req.divisor  = r_den;
            end
            ST_ZZ_GO: begin
                w_req.start = 1'b1;
                w_req.mul_a = {2'b0, r_zmag};
                w_req.mul_b = {2'b0, r_zmag};
            end
            ST_TM_GO: begin
                w_req.start = 1'b1;
                w_req.mul_a = {2'b0, r_term};
                w_req.mul_b = {2'b0, r_zz};
            end
            ST_TS_GO: begin
                w_req.start = 1'b1;
                w_req.mul_a = {2'b0, w_rsp.result[Q_FRAC +: 30]};
                w_req.mul_b = 32'(w_odd);
            end
            ST_TD_GO: begin
                // quotient stays below the previous term, so below 2^30
                w_req.start    = 1'b1;
                w_req.op       = UOP_DIV;
                w_req.dividend = w_rsp.result;
                w_req.divisor  = DV_W'(w_odd) + 33'd2;
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_eps     <= EPS_RESET;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_eps <= i_cfg_wdata;
            end
            if (r_state == ST_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_zero <= s_axis_tdata == 32'd0;
            r_neg  <= s_axis_tdata < ONE_Q16;
            r_num  <= (s_axis_tdata < ONE_Q16) ? (ONE_Q16 - s_axis_tdata)
                                                : (s_axis_tdata - ONE_Q16);
            r_den  <= {1'b0, s_axis_tdata} + {1'b0, ONE_Q16};
            r_n    <= '0;
        end
        case (r_state)
            ST_Z_WAIT: if (w_rsp.done) begin
                r_zmag <= w_rsp.result[29:0];
                r_term <= w_rsp.result[29:0];
                r_sum  <= SUM_W'(w_rsp.result[29:0]);
            end
            ST_ZZ_WAIT: if (w_rsp.done) begin
                r_zz <= w_rsp.result[Q_FRAC +: 30];
            end
            ST_TM_GO:   r_n <= r_n + 1'b1;
            ST_TD_WAIT: if (w_rsp.done) begin
                r_term <= w_rsp.result[29:0];
            end
            ST_ACC:     r_sum <= r_sum + SUM_W'(r_term);
            ST_OUT: if (w_out_free) begin
                if (r_zero) begin
                    r_m_data <= '0;
                    r_m_user <= '0;
                end else begin
                    r_m_data <= {3'b0, w_n32[12:0], w_log};
                    r_m_user <= {w_above, 1'b1};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

[rtl/core/lns_unit.sv]
// ----------------------------------------------------------------------------
// lns_unit - shared multiply / divide unit
// Multiply: 32x32 product, registered. Divide: restoring, one quotient
// bit per cycle, DIV_STEPS quotient bits, for quotients below 2^DIV_STEPS.
// ----------------------------------------------------------------------------
module lns_unit
    import lns_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DV_W-1:0]      r_rem;
    logic [DV_W-1:0]      r_dv;
    logic [DIV_STEPS-1:0] r_lo;
    logic [DIV_STEPS-1:0] r_q;
    logic [63:0]          r_res;

    logic [DV_W:0]        w_rem2;
    logic [DV_W:0]        w_diff;
    logic                 w_ge;
    logic [DIV_STEPS-1:0] w_q_next;

    always_comb begin
        w_rem2   = {r_rem, r_lo[DIV_STEPS-1]};
        w_ge     = w_rem2 >= {1'b0, r_dv};
        w_diff   = w_rem2 - {1'b0, r_dv};
        w_q_next = {r_q[DIV_STEPS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= w_ge ? w_diff[DV_W-1:0] : w_rem2[DV_W-1:0];
                r_lo  <= {r_lo[DIV_STEPS-2:0], 1'b0};
                r_q   <= w_q_next;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= 64'(w_q_next);
                end
            end else if (i_req.start) begin
                case (i_req.op)
                    UOP_MUL: begin
                        r_res  <= i_req.mul_a * i_req.mul_b;
                        r_done <= 1'b1;
                    end
                    UOP_DIV: begin
                        // high part is already below the divisor
                        r_rem  <= i_req.dividend[DIV_STEPS +: DV_W];
                        r_lo   <= i_req.dividend[DIV_STEPS-1:0];
                        r_dv   <= i_req.divisor;
                        r_q    <= '0;
                        r_cnt  <= '0;
                        r_busy <= 1'b1;
                    end
                    default: r_done <= 1'b0;
                endcase
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - natural_log_series self-checking bench
// Drives Q16.16 arguments through the slave stream with random gaps, stalls
// the master stream at random, predicts each ln(x) beat bit for bit and
// compares field by field. Epsilon is rewritten between drained phases.
// ----------------------------------------------------------------------------
module testbench;
    import lns_pkg::*;

    localparam int          MAX_TERMS  = 4096;
    localparam int          ITEMS_PER  = 50;
    // idle watchdog limit, well above the longest item at MAX_TERMS terms
    localparam int          IDLE_LIMIT = 600_000;

    typedef struct {
        logic [31:0] x_value;
        logic [31:0] log_value;
        logic [12:0] terms_used;
        logic        valid_res;
        logic        hit_limit;
    } ln_result_t;

    class ln_checker;
        logic [23:0] epsilon;
        ln_result_t  ln_expected[$];
        int          errors;

        function new();
            epsilon = EPS_RESET;
            errors  = 0;
        endfunction

        function int pending();
            return ln_expected.size();
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // atanh series on term magnitudes, sign applied at the end
        function ln_result_t predict_ln(input logic [31:0] x);
            logic [63:0] num, den, zmag, zz, term, total, thr, mag;
            logic [63:0] n;
            logic        neg;
            ln_result_t  r;
            r.x_value    = x;
            r.log_value  = '0;
            r.terms_used = '0;
            r.valid_res  = 1'b0;
            r.hit_limit  = 1'b0;
            if (x == '0) begin
                return r;
            end
            neg   = x < ONE_Q16;
            num   = neg ? 64'(ONE_Q16 - x) : 64'(x - ONE_Q16);
            den   = 64'(x) + 64'(ONE_Q16);
            zmag  = (num << Q_FRAC) / den;
            zz    = (zmag * zmag) >> Q_FRAC;
            thr   = 64'(epsilon) << 6;
            term  = zmag;
            total = zmag;
            n     = 0;
            do begin
                n++;
                term  = (((term * zz) >> Q_FRAC) * (2 * n - 1)) / (2 * n + 1);
                total = total + term;
            end while (term >= thr && n < MAX_TERMS);
            mag = total >> 5;
            if (neg) begin
                if (mag > 64'h8000_0000) begin
                    mag = 64'h8000_0000;
                end
                r.log_value = 32'd0 - mag[31:0];
            end else begin
                if (mag > 64'h7FFF_FFFF) begin
                    mag = 64'h7FFF_FFFF;
                end
                r.log_value = mag[31:0];
            end
            r.terms_used = n[12:0];
            r.valid_res  = 1'b1;
            r.hit_limit  = term >= thr;
            return r;
        endfunction

        function void note_x(input logic [31:0] x);
            ln_expected.push_back(predict_ln(x));
        endfunction

        task check_beat(input logic [47:0] data, input logic [1:0] flags);
            ln_result_t e;
            if (ln_expected.size() == 0) begin
                report($sformatf("unexpected beat data=%h user=%b", data, flags));
                return;
            end
            e = ln_expected.pop_front();
            if (data[31:0] !== e.log_value)
                report($sformatf("x=%h log_value exp %h got %h",
                                 e.x_value, e.log_value, data[31:0]));
            if (data[44:32] !== e.terms_used)
                report($sformatf("x=%h terms_used exp %0d got %0d",
                                 e.x_value, e.terms_used, data[44:32]));
            if (flags[0] !== e.valid_res)
                report($sformatf("x=%h valid_res exp %b got %b",
                                 e.x_value, e.valid_res, flags[0]));
            if (flags[1] !== e.hit_limit)
                report($sformatf("x=%h hit_limit exp %b got %b",
                                 e.x_value, e.hit_limit, flags[1]));
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [23:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    ln_checker sb = new();
    int        idle_cycles = 0;
    int        src_calm    = 0;

    natural_log_series #(
        .MAX_TERMS(MAX_TERMS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 200);
    endfunction

    function logic [31:0] pick_x(input bit wide);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return '0;
        if (r < 8)  return ONE_Q16;
        if (r < 14) return ONE_Q16 + $urandom_range(0, 64) - 32;
        if (wide && r < 65) return $urandom;
        // |z| stays at or below 0.8 so the series is short at any epsilon
        return $urandom_range(32'h0000_2000, 32'h0009_0000);
    endfunction

    task send_x(input logic [31:0] x);
        int gap;
        if (src_calm > 0) begin
            src_calm--;
            gap = 0;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 19) == 0) src_calm = $urandom_range(5, 20);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_x(x);
    endtask

    task drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task set_epsilon(input logic [23:0] eps);
        s_axis_tvalid <= 1'b0;
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= eps;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.epsilon = eps;
    endtask

    // result side: random back-pressure, with the odd long stretch of none
    initial begin
        int hold;
        int calm;
        hold = 0;
        calm = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_beat(m_axis_tdata, m_axis_tuser);
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (calm > 0)
                    calm--;
                else if ($urandom_range(0, 3) == 0)
                    hold = pick_gap();
                else if ($urandom_range(0, 29) == 0)
                    calm = $urandom_range(20, 200);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [23:0] eps_list[6];
        logic [23:0] eps;
        eps_list[0] = 24'hFF_FFFF;
        eps_list[1] = 24'd1;
        eps_list[2] = EPS_RESET;
        eps_list[3] = 24'($urandom_range(1 << 18, 1 << 23));
        eps_list[4] = 24'($urandom_range(1, 1 << 12));
        eps_list[5] = 24'h80_0000;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset epsilon: zero argument, unity, both sides of one, negative cap
        send_x(32'h0000_0000);
        send_x(ONE_Q16);
        send_x(32'h0000_8000);
        send_x(32'h0002_0000);
        send_x(32'h0001_0001);
        send_x(32'h0000_FFFF);
        send_x(32'h0000_0001);

        // largest epsilon: every term is below it after the first step
        set_epsilon(24'hFF_FFFF);
        send_x(32'hFFFF_FFFF);
        send_x(32'h0000_0001);
        send_x(32'h8000_0000);
        send_x(32'h5555_5555);
        send_x(32'hAAAA_AAAA);
        send_x(ONE_Q16);
        send_x(32'h0000_0000);

        // zero epsilon never stops early: runs to the cap even with z = 0
        set_epsilon(24'd0);
        send_x(ONE_Q16);

        foreach (eps_list[p]) begin
            eps = eps_list[p];
            set_epsilon(eps);
            repeat (ITEMS_PER) send_x(pick_x(eps >= (1 << 18)));
        end

        s_axis_tvalid <= 1'b0;
        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
